@@ sv/sdr_pkg.sv @@
`default_nettype none
package sdr_pkg;

	// field widths
	localparam int BLEN_W  = 10;
	localparam int TICK_W  = 16;
	localparam int CRC_W   = 16;
	localparam int APB_DW  = 32;
	localparam int APB_AW  = 4;

	// request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TIMEOUT   = 2'd1;
	localparam logic [1:0] ST_BAD_TOKEN = 2'd2;
	localparam logic [1:0] ST_CRC_ERR   = 2'd3;

	// register indexes (byte address = 4 * index)
	localparam logic [1:0] REG_BLOCK_LENGTH = 2'd0;
	localparam logic [1:0] REG_CRC_ENABLE   = 2'd1;
	localparam logic [1:0] REG_TIMEOUT      = 2'd2;
	localparam logic [1:0] REG_START_TOKEN  = 2'd3;

	// register reset values
	localparam logic [BLEN_W-1:0] RST_BLOCK_LENGTH = 10'd512;
	localparam logic              RST_CRC_ENABLE   = 1'b1;
	localparam logic [TICK_W-1:0] RST_TIMEOUT      = 16'd300;
	localparam logic [7:0]        RST_START_TOKEN  = 8'hFE;

	localparam logic [7:0]       FILL_BYTE = 8'hFF;
	localparam logic [CRC_W-1:0] CRC_POLY  = 16'h1021;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WAIT,
		PH_DATA,
		PH_CRC_HI,
		PH_CRC_LO
	} phase_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last;
	} res_t;

	// CRC-16/XMODEM, one byte folded in, MSB first
	function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] crc,
			input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

@@ sv/sdr_stream_if.sv @@
`default_nettype none
interface sdr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/sd_data_block_receiver.sv @@
`default_nettype none
// SD data block receiver, SPI mode, CRC-16/XMODEM check.
// A beat is captured in the input register and its result in the result register.
// Throughput: one beat per cycle while the result register is empty or being taken;
// the state update with its byte-wide CRC fold is combinational between the two registers.
// Reset: arst_n clears phase to idle, counters and CRC to zero, registers to defaults.
module sd_data_block_receiver #(
	parameter int MAX_BLOCK_LENGTH = 512
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	sdr_stream_if.sink                       req,
	sdr_stream_if.source                     res,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [sdr_pkg::APB_AW-1:0]  paddr,
	input  wire logic [sdr_pkg::APB_DW-1:0]  pwdata,
	output logic      [sdr_pkg::APB_DW-1:0]  prdata,
	output logic                             pready
);
	import sdr_pkg::*;

	// longest block the 10-bit counter can reach
	localparam int BLEN_MAX = (1 << BLEN_W) - 1;
	localparam logic [BLEN_W-1:0] EFF_MAX = (MAX_BLOCK_LENGTH > BLEN_MAX) ?
		BLEN_W'(BLEN_MAX) : BLEN_W'(MAX_BLOCK_LENGTH);

	// configuration registers
	logic [BLEN_W-1:0] block_length_q;
	logic              crc_enable_q;
	logic [TICK_W-1:0] timeout_q;
	logic [7:0]        start_token_q;

	logic [1:0] reg_idx;
	logic       cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_length_q <= RST_BLOCK_LENGTH;
			crc_enable_q   <= RST_CRC_ENABLE;
			timeout_q      <= RST_TIMEOUT;
			start_token_q  <= RST_START_TOKEN;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BLOCK_LENGTH: block_length_q <= pwdata[BLEN_W-1:0];
				REG_CRC_ENABLE:   crc_enable_q   <= pwdata[0];
				REG_TIMEOUT:      timeout_q      <= pwdata[TICK_W-1:0];
				REG_START_TOKEN:  start_token_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_BLOCK_LENGTH: prdata = APB_DW'(block_length_q);
			REG_CRC_ENABLE:   prdata = APB_DW'(crc_enable_q);
			REG_TIMEOUT:      prdata = APB_DW'(timeout_q);
			REG_START_TOKEN:  prdata = APB_DW'(start_token_q);
			default:          prdata = '0;
		endcase
	end

	// input register
	logic valid_s1;
	req_t item_s1;
	logic advance;
	logic res_valid_q;
	res_t res_data_q;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			item_s1 <= req.data;
		end
	end

	// receive state
	phase_t            phase_q, phase_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [BLEN_W-1:0] count_q, count_d;
	logic [CRC_W-1:0]  crc_q, crc_d;
	logic [7:0]        crc_hi_q, crc_hi_d;
	logic              emit;
	res_t              res_d;
	logic [BLEN_W-1:0] eff_len;
	logic [BLEN_W-1:0] count_inc;

	// zero acts as one, long blocks clip to the maximum
	always_comb begin
		if (block_length_q == '0) begin
			eff_len = BLEN_W'(1);
		end else if (block_length_q > EFF_MAX) begin
			eff_len = EFF_MAX;
		end else begin
			eff_len = block_length_q;
		end
	end

	assign count_inc = count_q + BLEN_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tick_q   <= '0;
			count_q  <= '0;
			crc_q    <= '0;
			crc_hi_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			count_q  <= count_d;
			crc_q    <= crc_d;
			crc_hi_q <= crc_hi_d;
		end
	end

	// next state and result for the beat in the input register
	always_comb begin
		phase_d  = phase_q;
		tick_d   = tick_q;
		count_d  = count_q;
		crc_d    = crc_q;
		crc_hi_d = crc_hi_q;
		emit     = 1'b0;
		res_d    = '{result_kind: KIND_STATUS, data_byte: 8'h00, status: ST_OK, last: 1'b1};
		case (item_s1.req_type)
			REQ_START: begin
				phase_d  = PH_WAIT;
				tick_d   = '0;
				count_d  = '0;
				crc_d    = '0;
				crc_hi_d = '0;
			end
			REQ_TICK: begin
				if (phase_q == PH_WAIT) begin
					if (tick_q >= timeout_q) begin
						phase_d      = PH_IDLE;
						emit         = 1'b1;
						res_d.status = ST_TIMEOUT;
					end else begin
						tick_d = tick_q + TICK_W'(1);
					end
				end
			end
			REQ_BYTE: begin
				unique case (phase_q)
					PH_WAIT: begin
						if (item_s1.rx_byte == FILL_BYTE) begin
							phase_d = PH_WAIT;
						end else if (item_s1.rx_byte == start_token_q) begin
							phase_d = PH_DATA;
							count_d = '0;
							crc_d   = '0;
						end else begin
							phase_d         = PH_IDLE;
							emit            = 1'b1;
							res_d.data_byte = item_s1.rx_byte;
							res_d.status    = ST_BAD_TOKEN;
						end
					end
					PH_DATA: begin
						crc_d   = crc_fold(crc_q, item_s1.rx_byte);
						count_d = count_inc;
						if (count_inc >= eff_len) begin
							phase_d = PH_CRC_HI;
						end
						emit  = 1'b1;
						res_d = '{result_kind: KIND_DATA, data_byte: item_s1.rx_byte,
							status: ST_OK, last: 1'b0};
					end
					PH_CRC_HI: begin
						crc_hi_d = item_s1.rx_byte;
						phase_d  = PH_CRC_LO;
					end
					PH_CRC_LO: begin
						phase_d = PH_IDLE;
						emit    = 1'b1;
						if (crc_enable_q && ({crc_hi_q, item_s1.rx_byte} != crc_q)) begin
							res_d.status = ST_CRC_ERR;
						end
					end
					default: phase_d = phase_q;
				endcase
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_data_q <= res_d;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

endmodule
`default_nettype wire
